@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the coloring enumerator modules.
// Each macro expects clk and arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GCE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GCE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/gce_pkg.sv @@
// ---------------------------------------------------------------------------
// gce_pkg
// Types and constants of the graph coloring enumerator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gce_pkg;

	localparam int DEF_MAX_VERTICES = 16;
	localparam int DEF_MAX_COLORS   = 4;

	localparam int VERTEX_COUNT_W = 5;
	localparam int COLOR_COUNT_W  = 3;
	localparam int CFG_INDEX_W    = 1;
	localparam int CFG_DATA_W     = 5;
	localparam int FUNC_W         = 2;
	localparam int ROW_INDEX_W    = 4;
	localparam int ROW_BITS_W     = 16;
	localparam int COLOR_W        = 2;
	localparam int COLORING_W     = 32;
	localparam int S_TDATA_W      = 24;
	localparam int S_TUSER_W      = 2;
	localparam int M_TDATA_W      = 32;
	localparam int M_TUSER_W      = 2;

	localparam logic [VERTEX_COUNT_W-1:0] VERTEX_COUNT_RST = 5'd6;
	localparam logic [COLOR_COUNT_W-1:0]  COLOR_COUNT_RST  = 3'd3;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_LOAD    = 2'd0,
		FUNC_RESTART = 2'd1,
		FUNC_FIND    = 2'd2
	} func_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_VERTEX_COUNT = 1'b0,
		CFG_COLOR_COUNT  = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_FOUND,
		RES_EXHAUSTED
	} res_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ADVANCE,
		ST_EMIT_ZERO,
		ST_EMIT_FOUND,
		ST_EMIT_EXH
	} state_t;

	typedef struct packed {
		logic      load_row;
		logic      rewind;
		logic      start;
		logic      resume;
		logic      adv;
		logic      descend;
		logic      fin;
		logic      emit;
		res_kind_t kind;
	} dp_cmd_t;

	typedef struct packed {
		logic finished;
		logic active;
		logic ok;
		logic last;
		logic can_inc;
		logic at_root;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

@@ hdl/gce_ctrl.sv @@
// ---------------------------------------------------------------------------
// gce_ctrl
// Search controller: decodes transactions and sequences check/advance steps.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gce_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire logic [gce_pkg::FUNC_W-1:0]  func,
	output logic                             in_ready,
	output gce_pkg::dp_cmd_t                 cmd,
	input  wire gce_pkg::dp_stat_t           stat
);

	gce_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gce_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.kind = gce_pkg::RES_ZERO;
		unique case (state_q)
			gce_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (func)
						gce_pkg::FUNC_LOAD: begin
							cmd.load_row = 1'b1;
							state_nx     = gce_pkg::ST_EMIT_ZERO;
						end
						gce_pkg::FUNC_RESTART: begin
							cmd.rewind = 1'b1;
							state_nx   = gce_pkg::ST_EMIT_ZERO;
						end
						gce_pkg::FUNC_FIND: begin
							if (stat.finished) begin
								state_nx = gce_pkg::ST_EMIT_EXH;
							end else if (!stat.active) begin
								cmd.start = 1'b1;
								state_nx  = gce_pkg::ST_CHECK;
							end else begin
								cmd.resume = 1'b1;
								state_nx   = gce_pkg::ST_ADVANCE;
							end
						end
						default: begin
							state_nx = gce_pkg::ST_EMIT_ZERO;
						end
					endcase
				end
			end
			gce_pkg::ST_CHECK: begin
				if (stat.ok) begin
					if (stat.last) begin
						state_nx = gce_pkg::ST_EMIT_FOUND;
					end else begin
						cmd.descend = 1'b1;
					end
				end else begin
					state_nx = gce_pkg::ST_ADVANCE;
				end
			end
			gce_pkg::ST_ADVANCE: begin
				cmd.adv = 1'b1;
				if (stat.can_inc) begin
					state_nx = gce_pkg::ST_CHECK;
				end else if (stat.at_root) begin
					cmd.fin  = 1'b1;
					state_nx = gce_pkg::ST_EMIT_EXH;
				end
			end
			gce_pkg::ST_EMIT_ZERO: begin
				cmd.kind = gce_pkg::RES_ZERO;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_nx = gce_pkg::ST_IDLE;
				end
			end
			gce_pkg::ST_EMIT_FOUND: begin
				cmd.kind = gce_pkg::RES_FOUND;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_nx = gce_pkg::ST_IDLE;
				end
			end
			gce_pkg::ST_EMIT_EXH: begin
				cmd.kind = gce_pkg::RES_EXHAUSTED;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_nx = gce_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = gce_pkg::ST_IDLE;
			end
		endcase
	end

	`GCE_ASSERT_NOW(a_emit_free, cmd.emit, stat.out_free, "result loaded while output busy")
	`GCE_ASSERT_NOW(a_descend_last, cmd.descend, !stat.last, "descend past last vertex")
	`GCE_ASSERT_NOW(a_fin_root, cmd.fin, stat.at_root && !stat.can_inc, "search ended off root")

endmodule

`default_nettype wire

@@ hdl/gce_datapath.sv @@
// ---------------------------------------------------------------------------
// gce_datapath
// Adjacency rows, color assignment, search depth and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gce_datapath #(
	parameter int MAX_VERTICES = gce_pkg::DEF_MAX_VERTICES,
	parameter int MAX_COLORS   = gce_pkg::DEF_MAX_COLORS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [gce_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [gce_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic [gce_pkg::ROW_INDEX_W-1:0]    row_index,
	input  wire logic [gce_pkg::ROW_BITS_W-1:0]     row_bits,
	input  wire gce_pkg::dp_cmd_t                   cmd,
	output gce_pkg::dp_stat_t                       stat,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [gce_pkg::COLORING_W-1:0]          out_coloring,
	output logic                                    out_found,
	output logic                                    out_exhausted
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CW = gce_pkg::COLOR_W;
	localparam logic [gce_pkg::VERTEX_COUNT_W-1:0] VMAX =
		gce_pkg::VERTEX_COUNT_W'(MAX_VERTICES);
	localparam logic [gce_pkg::COLOR_COUNT_W-1:0] CMAX =
		gce_pkg::COLOR_COUNT_W'(MAX_COLORS);
	localparam logic [gce_pkg::ROW_INDEX_W:0] RMAX =
		(gce_pkg::ROW_INDEX_W + 1)'(MAX_VERTICES);

	logic [gce_pkg::VERTEX_COUNT_W-1:0] vcount_q;
	logic [gce_pkg::COLOR_COUNT_W-1:0]  ccount_q;
	logic [MAX_VERTICES-1:0]            adj_q [MAX_VERTICES];
	logic [CW-1:0]                      color_q [MAX_VERTICES];
	logic [VW-1:0]                      d_q;
	logic                               active_q;
	logic                               finished_q;

	logic [gce_pkg::VERTEX_COUNT_W-1:0] vc_m1;
	logic [gce_pkg::COLOR_COUNT_W-1:0]  cc_m1;
	logic [VW-1:0]                      last_v;
	logic [CW-1:0]                      last_c;
	logic [MAX_VERTICES-1:0]            adj_row;
	logic [CW-1:0]                      cur_color;
	logic                               conflict;
	logic [VW-1:0]                      d_up;
	logic                               row_ok;
	logic                               out_free;
	logic [gce_pkg::COLORING_W-1:0]     word;

	assign vc_m1 = vcount_q - gce_pkg::VERTEX_COUNT_W'(1);
	assign cc_m1 = ccount_q - gce_pkg::COLOR_COUNT_W'(1);

	always_comb begin
		priority if (vcount_q == '0) begin
			last_v = '0;
		end else if (vcount_q > VMAX) begin
			last_v = VW'(MAX_VERTICES - 1);
		end else begin
			last_v = vc_m1[VW-1:0];
		end
		priority if (ccount_q == '0) begin
			last_c = '0;
		end else if (ccount_q > CMAX) begin
			last_c = CW'(MAX_COLORS - 1);
		end else begin
			last_c = cc_m1[CW-1:0];
		end
	end

	assign adj_row   = adj_q[d_q];
	assign cur_color = color_q[d_q];
	assign d_up      = d_q + VW'(1);
	assign row_ok    = {1'b0, row_index} < RMAX;
	assign out_free  = !out_valid || out_ready;

	always_comb begin
		conflict = 1'b0;
		for (int j = 0; j < MAX_VERTICES; j++) begin
			if (adj_row[j] && (VW'(j) < d_q) && (color_q[j] == cur_color)) begin
				conflict = 1'b1;
			end
		end
	end

	always_comb begin
		word = '0;
		for (int v = 0; v < MAX_VERTICES; v++) begin
			if (VW'(v) <= last_v) begin
				word[2*v +: 2] = color_q[v];
			end
		end
	end

	assign stat.finished = finished_q;
	assign stat.active   = active_q;
	assign stat.ok       = !conflict;
	assign stat.last     = d_q == last_v;
	assign stat.can_inc  = cur_color < last_c;
	assign stat.at_root  = d_q == '0;
	assign stat.out_free = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q   <= gce_pkg::VERTEX_COUNT_RST;
			ccount_q   <= gce_pkg::COLOR_COUNT_RST;
			d_q        <= '0;
			active_q   <= 1'b0;
			finished_q <= 1'b0;
			for (int i = 0; i < MAX_VERTICES; i++) begin
				adj_q[i]   <= '0;
				color_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (gce_pkg::cfg_idx_t'(cfg_index))
					gce_pkg::CFG_VERTEX_COUNT: vcount_q <= cfg_data[gce_pkg::VERTEX_COUNT_W-1:0];
					gce_pkg::CFG_COLOR_COUNT:  ccount_q <= cfg_data[gce_pkg::COLOR_COUNT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load_row && row_ok) begin
				adj_q[row_index[VW-1:0]] <= row_bits[MAX_VERTICES-1:0];
			end
			if (cfg_we || cmd.rewind || cmd.start) begin
				for (int i = 0; i < MAX_VERTICES; i++) begin
					color_q[i] <= '0;
				end
				d_q        <= '0;
				active_q   <= cmd.start && !cfg_we;
				finished_q <= 1'b0;
			end else begin
				if (cmd.resume) begin
					d_q <= last_v;
				end
				if (cmd.descend) begin
					d_q          <= d_up;
					color_q[d_up] <= '0;
				end
				if (cmd.adv) begin
					if (stat.can_inc) begin
						color_q[d_q] <= cur_color + CW'(1);
					end else begin
						color_q[d_q] <= '0;
						if (d_q != '0) begin
							d_q <= d_q - VW'(1);
						end
					end
				end
				if (cmd.fin) begin
					finished_q <= 1'b1;
					d_q        <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_coloring  <= (cmd.kind == gce_pkg::RES_FOUND) ? word : '0;
			out_found     <= cmd.kind == gce_pkg::RES_FOUND;
			out_exhausted <= cmd.kind == gce_pkg::RES_EXHAUSTED;
		end
	end

	`GCE_ASSERT_NOW(a_flags_excl, out_valid, !(out_found && out_exhausted), "found and exhausted")
	`GCE_ASSERT_NOW(a_fin_depth, finished_q, d_q == '0 && active_q, "finished search off root")
	`GCE_ASSERT_NOW(a_depth_range, 1'b1, d_q <= last_v, "depth beyond vertex count")

endmodule

`default_nettype wire

@@ hdl/graph_coloring_enumerator.sv @@
// ---------------------------------------------------------------------------
// graph_coloring_enumerator
// Depth-first backtracking enumeration of proper vertex colorings.
// ---------------------------------------------------------------------------
// channel  dir  handshake          payload
// s_axis   in   s_tvalid/s_tready  tdata: row_index, row_bits; tuser: func
// m_axis   out  m_tvalid/m_tready  tdata: coloring; tuser: found, exhausted
// cfg      in   cfg_we             cfg_index, cfg_data
//
// Load, restart and unused codes: accepted while idle, then a zero result
// is emitted once the output register is free. Find next: the search
// controller runs check and backtrack steps whose count depends on the
// graph (worst case grows with color_count ** vertex_count).
// Reset clears all rows, colors and search flags at once; no clearing pass.
// A result waiting on m_tready blocks only the next result, not acceptance.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module graph_coloring_enumerator #(
	parameter int MAX_VERTICES = gce_pkg::DEF_MAX_VERTICES,
	parameter int MAX_COLORS   = gce_pkg::DEF_MAX_COLORS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [gce_pkg::S_TDATA_W-1:0]     s_tdata,  // row_index[3:0], row_bits[19:4]
	input  wire logic [gce_pkg::S_TUSER_W-1:0]     s_tuser,  // func[1:0]
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [gce_pkg::M_TDATA_W-1:0]          m_tdata,  // coloring[31:0]
	output logic [gce_pkg::M_TUSER_W-1:0]          m_tuser,  // found[0], exhausted[1]
	input  wire logic                              cfg_we,
	input  wire logic [gce_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [gce_pkg::CFG_DATA_W-1:0]    cfg_data
);

	gce_pkg::dp_cmd_t  cmd;
	gce_pkg::dp_stat_t stat;
	logic              in_ready;
	logic              found;
	logic              exhausted;

	assign s_tready = in_ready;
	assign m_tuser  = {exhausted, found};

	gce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.func     (s_tuser[gce_pkg::FUNC_W-1:0]),
		.in_ready (in_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	gce_datapath #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_COLORS   (MAX_COLORS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.row_index     (s_tdata[gce_pkg::ROW_INDEX_W-1:0]),
		.row_bits      (s_tdata[gce_pkg::ROW_INDEX_W +: gce_pkg::ROW_BITS_W]),
		.cmd           (cmd),
		.stat          (stat),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_coloring  (m_tdata),
		.out_found     (found),
		.out_exhausted (exhausted)
	);

endmodule

`default_nettype wire

@@ tb/sv/tb_graph_coloring_enumerator.sv @@
// ---------------------------------------------------------------------------
// tb_graph_coloring_enumerator
// Self-checking bench for the backtracking graph coloring enumerator.
// Loads adjacency rows, restarts and steps the search through directed
// corner cases and random phases over many vertex and color counts, with
// random stalls on both streams. Every result is checked against an
// in-bench search that walks the same colorings in the same order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_graph_coloring_enumerator;
	import gce_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int PAD_W = S_TDATA_W - ROW_INDEX_W - ROW_BITS_W;
	localparam int WATCHDOG_LIMIT = 500000;

	typedef struct packed {
		logic [FUNC_W-1:0]      func;
		logic [ROW_INDEX_W-1:0] row;
		logic [ROW_BITS_W-1:0]  bits;
	} gc_item_t;

	typedef struct packed {
		logic [COLORING_W-1:0] coloring;
		logic                  found;
		logic                  exhausted;
	} coloring_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [S_TUSER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	graph_coloring_enumerator uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// search state mirror
	logic [ROW_BITS_W-1:0]     adj_rows [16];
	logic [COLOR_W-1:0]        vcol [16];
	logic [4:0]                depth_r;
	bit                        srch_active;
	bit                        srch_done;
	logic [VERTEX_COUNT_W-1:0] vcount_reg;
	logic [COLOR_COUNT_W-1:0]  ccount_reg;
	int                        cur_v;

	gc_item_t      item_q [$];
	coloring_res_t coloring_q [$];

	bit in_taken = 1'b0;
	bit gaps_on = 1'b1;
	int errors = 0;
	int idle_cycles = 0;
	int n_in = 0;
	int n_found = 0;
	int n_exh = 0;
	int n_writes = 0;

	function automatic void rewind_search();
		foreach (vcol[i]) vcol[i] = '0;
		depth_r = '0;
		srch_active = 1'b0;
		srch_done = 1'b0;
	endfunction

	function automatic bit vertex_clear(int d);
		for (int j = 0; j < d; j++)
			if (adj_rows[d][j] && vcol[j] == vcol[d]) return 1'b0;
		return 1'b1;
	endfunction

	// move to the next candidate, backing up as needed; 0 when the tree is used up
	function automatic bit backtrack(int nc);
		while (1) begin
			if (vcol[cur_v] + 1 < nc) begin
				vcol[cur_v] = vcol[cur_v] + 1'b1;
				return 1'b1;
			end
			vcol[cur_v] = '0;
			if (cur_v == 0) return 1'b0;
			cur_v--;
		end
		return 1'b0;
	endfunction

	function automatic coloring_res_t next_coloring(logic [FUNC_W-1:0] func,
			logic [ROW_INDEX_W-1:0] row, logic [ROW_BITS_W-1:0] bits);
		coloring_res_t r;
		int nv, nc;
		bit ok;
		r = '0;
		if (func == FUNC_LOAD) begin
			adj_rows[row] = bits;
			return r;
		end
		if (func == FUNC_RESTART) begin
			rewind_search();
			return r;
		end
		if (func != FUNC_FIND) return r;
		if (srch_done) begin
			r.exhausted = 1'b1;
			return r;
		end
		nv = (vcount_reg == 0) ? 1 : (vcount_reg > 16) ? 16 : vcount_reg;
		nc = (ccount_reg == 0) ? 1 : (ccount_reg > 4) ? 4 : ccount_reg;
		ok = 1'b1;
		if (!srch_active) begin
			foreach (vcol[i]) vcol[i] = '0;
			cur_v = 0;
			srch_active = 1'b1;
		end else begin
			cur_v = nv - 1;
			ok = backtrack(nc);
		end
		while (ok) begin
			if (vertex_clear(cur_v)) begin
				if (cur_v == nv - 1) break;
				cur_v++;
				vcol[cur_v] = '0;
			end else begin
				ok = backtrack(nc);
			end
		end
		if (!ok) begin
			srch_done = 1'b1;
			depth_r = '0;
			r.exhausted = 1'b1;
			return r;
		end
		depth_r = cur_v[4:0];
		for (int v = 0; v < nv; v++) r.coloring[2*v +: 2] = vcol[v];
		r.found = 1'b1;
		return r;
	endfunction

	function automatic logic [ROW_BITS_W-1:0] rand_row();
		logic [ROW_BITS_W-1:0] a, b;
		a = $urandom;
		b = $urandom;
		case ($urandom_range(2))
			0: return a & b;
			1: return a | b;
			default: return a;
		endcase
	endfunction

	task automatic queue_item(logic [FUNC_W-1:0] f, logic [ROW_INDEX_W-1:0] r,
			logic [ROW_BITS_W-1:0] b);
		gc_item_t it;
		it.func = f;
		it.row = r;
		it.bits = b;
		item_q.push_back(it);
	endtask

	task automatic drain();
		while (item_q.size() != 0 || s_tvalid || coloring_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == CFG_VERTEX_COUNT) vcount_reg = val[VERTEX_COUNT_W-1:0];
		else ccount_reg = val[COLOR_COUNT_W-1:0];
		rewind_search();
		n_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(int n_items);
		int nc, nv, cap, pick;
		logic [CFG_DATA_W-1:0] raw_v, raw_c;
		raw_c = CFG_DATA_W'($urandom_range(31));
		nc = (raw_c[2:0] == 0) ? 1 : (raw_c[2:0] > 4) ? 4 : raw_c[2:0];
		// keep the search tree small enough for full exhaustion
		cap = (nc == 1) ? 16 : (nc == 2) ? 10 : (nc == 3) ? 6 : 5;
		nv = $urandom_range(cap, 1);
		raw_v = CFG_DATA_W'(nv);
		if (nv == 1 && $urandom_range(1)) raw_v = '0;
		if (nv == 16 && $urandom_range(1)) raw_v = CFG_DATA_W'($urandom_range(31, 16));
		write_reg(CFG_COLOR_COUNT, raw_c);
		write_reg(CFG_VERTEX_COUNT, raw_v);
		for (int k = 0; k < nv; k++) queue_item(FUNC_LOAD, 4'(k), rand_row());
		queue_item(FUNC_RESTART, 4'($urandom), 16'($urandom));
		repeat (n_items) begin
			pick = $urandom_range(99);
			if (pick < 55)
				queue_item(FUNC_FIND, 4'($urandom), 16'($urandom));
			else if (pick < 75)
				queue_item(FUNC_LOAD, 4'($urandom_range(nv - 1)), rand_row());
			else if (pick < 83)
				queue_item(FUNC_LOAD, 4'($urandom), 16'($urandom));
			else if (pick < 91)
				queue_item(FUNC_RESTART, 4'($urandom), 16'($urandom));
			else
				queue_item(FUNC_UNUSED, 4'($urandom), 16'($urandom));
		end
		drain();
	endtask

	// input driver
	always @(negedge clk) begin : drv
		gc_item_t it;
		if (arst_n) begin
			if (!s_tvalid || in_taken) begin
				if (item_q.size() != 0 && !(gaps_on && $urandom_range(99) < 19)) begin
					it = item_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {{PAD_W{1'b0}}, it.bits, it.row};
					s_tuser <= it.func;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= !(gaps_on && $urandom_range(99) < 19);
		end
	end

	// monitor, checker and watchdog
	always @(posedge clk) begin : mon
		coloring_res_t want;
		bit out_taken;
		if (arst_n) begin
			in_taken = s_tvalid && s_tready;
			out_taken = m_tvalid && m_tready;
			if (in_taken) begin
				want = next_coloring(s_tuser, s_tdata[ROW_INDEX_W-1:0],
					s_tdata[ROW_INDEX_W +: ROW_BITS_W]);
				coloring_q.push_back(want);
				n_in++;
			end
			if (out_taken) begin
				if (coloring_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected result coloring %h tuser %b",
							$realtime, m_tdata, m_tuser);
				end else begin
					want = coloring_q.pop_front();
					n_found += want.found;
					n_exh += want.exhausted;
					if (m_tdata !== want.coloring || m_tuser[0] !== want.found ||
							m_tuser[1] !== want.exhausted) begin
						errors++;
						if (errors <= 10)
							$display("%0t: result error coloring exp %h got %h, found exp %b got %b, exhausted exp %b got %b",
								$realtime, want.coloring, m_tdata, want.found, m_tuser[0],
								want.exhausted, m_tuser[1]);
					end
				end
			end
			if (in_taken || out_taken) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $realtime, idle_cycles);
				$display("graph_coloring_enumerator: mismatch");
				$finish;
			end
		end
	end

	initial begin
		vcount_reg = VERTEX_COUNT_RST;
		ccount_reg = COLOR_COUNT_RST;
		foreach (adj_rows[i]) adj_rows[i] = '0;
		rewind_search();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: empty graph, then a triangle on vertices 0..2
		queue_item(FUNC_FIND, 4'd0, 16'h0000);
		queue_item(FUNC_LOAD, 4'd0, 16'hFFFF);
		queue_item(FUNC_LOAD, 4'd1, 16'h0001);
		queue_item(FUNC_LOAD, 4'd2, 16'h0003);
		queue_item(FUNC_LOAD, 4'd15, 16'hFFFF);
		queue_item(FUNC_RESTART, 4'hF, 16'hFFFF);
		repeat (3) queue_item(FUNC_FIND, 4'hF, 16'hFFFF);
		queue_item(FUNC_UNUSED, 4'hF, 16'hFFFF);
		// new row while the search is under way
		queue_item(FUNC_LOAD, 4'd4, 16'h0008);
		repeat (2) queue_item(FUNC_FIND, 4'd0, 16'h0000);
		queue_item(FUNC_RESTART, 4'd0, 16'h0000);
		drain();

		// one color: triangle cannot be colored
		write_reg(CFG_COLOR_COUNT, 5'd1);
		repeat (2) queue_item(FUNC_FIND, 4'd0, 16'h0000);
		queue_item(FUNC_RESTART, 4'd0, 16'h0000);
		queue_item(FUNC_FIND, 4'd0, 16'h0000);
		drain();

		// zero counts read as one
		write_reg(CFG_VERTEX_COUNT, 5'd0);
		write_reg(CFG_COLOR_COUNT, 5'd0);
		repeat (3) queue_item(FUNC_FIND, 4'd0, 16'h0000);
		drain();

		// saturated counts on a 16-vertex path
		write_reg(CFG_VERTEX_COUNT, 5'd31);
		write_reg(CFG_COLOR_COUNT, 5'd7);
		for (int k = 0; k < 16; k++)
			queue_item(FUNC_LOAD, 4'(k), (k == 0) ? 16'h0000 : 16'(1 << (k - 1)));
		queue_item(FUNC_RESTART, 4'd0, 16'h0000);
		repeat (6) queue_item(FUNC_FIND, 4'd0, 16'h0000);
		drain();

		// two colors on the path: two colorings, then exhausted
		write_reg(CFG_VERTEX_COUNT, 5'd16);
		write_reg(CFG_COLOR_COUNT, 5'd2);
		repeat (4) queue_item(FUNC_FIND, 4'd0, 16'h0000);
		drain();

		write_reg(CFG_VERTEX_COUNT, 5'd1);
		write_reg(CFG_COLOR_COUNT, 5'd4);
		repeat (6) queue_item(FUNC_FIND, 4'd0, 16'h0000);
		drain();

		for (int p = 0; p < 9; p++) begin
			gaps_on = (p != 4);
			random_phase(45);
		end
		gaps_on = 1'b1;
		repeat (20) @(posedge clk);

		$display("run covered %0d input transactions: %0d colorings found, %0d exhausted results",
			n_in, n_found, n_exh);
		$display("%0d register writes over vertex counts 0..31 and color counts 0..7", n_writes);
		if (errors == 0 && coloring_q.size() == 0) begin
			$display("graph_coloring_enumerator: match");
		end else begin
			$display("graph_coloring_enumerator: mismatch");
		end
		$finish;
	end

endmodule
